[rtl/dpkv_pkg.sv]
// shared constants and codes for the depth-preferred key/value table
`default_nettype none

package dpkv_pkg;

    // default sizes
    localparam int ENTRIES_DEF     = 1024;
    localparam int HEIGHT_BITS_DEF = 8;
    localparam int SCORE_BITS_DEF  = 16;

    // fixed field widths
    localparam int KEY_W   = 64;
    localparam int OP_W    = 2;
    localparam int CAP_W   = 11;
    localparam int HIT_W   = 32;
    localparam int USAGE_W = 10;

    // capacity after reset, before clamping to the table size
    localparam int CAP_RESET = 1024;

    // usage scale
    localparam int PER_MIL = 1000;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

`default_nettype wire

[rtl/dpkv_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module dpkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/dpkv_div.sv]
// restoring divider for count * 1000 / capacity, one quotient bit per cycle
`default_nettype none

module dpkv_div #(
    parameter int CNT_W = 11
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire logic [CNT_W-1:0]            i_divisor,
    output logic                             o_done,
    output logic [dpkv_pkg::USAGE_W-1:0]     o_quot
);

    localparam int DIV_W = CNT_W + dpkv_pkg::USAGE_W;
    localparam int CW    = $clog2(DIV_W + 1);

    logic             r_run;
    logic [CW-1:0]    r_cnt;
    logic [CNT_W-1:0] r_rem;
    logic [DIV_W-1:0] r_q;
    logic [CNT_W-1:0] r_dvs;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_q[DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out at the top, quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= DIV_W'(i_count) * DIV_W'(dpkv_pkg::PER_MIL);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    // quotient never exceeds 1000
    assign o_quot = r_q[dpkv_pkg::USAGE_W-1:0];

endmodule

`default_nettype wire

[rtl/depth_preferred_key_value_table.sv]
// top level: sequencer, entry scan and update of the depth-preferred key/value table
//
// One command is taken when start is high and busy is low; busy then stays high
// until the single result has been shown for one cycle with o_valid, and the
// receiver must take it in that cycle. Entries sit packed in one ram from slot 0
// up to the entry count, so a lookup or store scans them one per cycle through
// the ram's registered read port while 64-bit compares check each key for a
// match and for the smallest key. After the update a restoring divider forms
// the usage figure, one bit per cycle. Clear and the unused code skip the scan.
// A capacity write empties the table at once; no clearing sweep is needed. It
// is to be written only while busy is low; the block itself does not enforce this.
`default_nettype none

module depth_preferred_key_value_table #(
    parameter int ENTRIES     = dpkv_pkg::ENTRIES_DEF,
    parameter int HEIGHT_BITS = dpkv_pkg::HEIGHT_BITS_DEF,
    parameter int SCORE_BITS  = dpkv_pkg::SCORE_BITS_DEF,
    localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [dpkv_pkg::CAP_W-1:0]        i_cfg_wdata,
    // command
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [dpkv_pkg::OP_W-1:0]         i_op,
    input  wire logic [dpkv_pkg::KEY_W-1:0]        i_key,
    input  wire logic [HEIGHT_BITS-1:0]            i_height,
    input  wire logic signed [SCORE_BITS-1:0]      i_best_value,
    input  wire logic signed [SCORE_BITS-1:0]      i_alpha,
    input  wire logic signed [SCORE_BITS-1:0]      i_beta,
    // result
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic signed [SCORE_BITS-1:0]           o_best_value_out,
    output logic signed [SCORE_BITS-1:0]           o_alpha_out,
    output logic signed [SCORE_BITS-1:0]           o_beta_out,
    output logic [CNT_W-1:0]                       o_entry_count,
    output logic [dpkv_pkg::HIT_W-1:0]             o_hit_count,
    output logic [dpkv_pkg::USAGE_W-1:0]           o_usage_per_mil
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int KW    = dpkv_pkg::KEY_W;
    localparam int HB    = HEIGHT_BITS;
    localparam int SB    = SCORE_BITS;
    localparam int ENT_W = KW + HB + 3 * SB;
    localparam int WW    = (dpkv_pkg::CAP_W > CNT_W) ? dpkv_pkg::CAP_W : CNT_W;
    localparam int CAP_INIT = (dpkv_pkg::CAP_RESET > ENTRIES) ? ENTRIES
                                                               : dpkv_pkg::CAP_RESET;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_ACT   = 6'b000100,
        S_DIVGO = 6'b001000,
        S_DIVW  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // command capture
    logic [dpkv_pkg::OP_W-1:0] r_op;
    logic [KW-1:0]             r_key;
    logic [HB-1:0]             r_height;
    logic [SB-1:0]             r_best;
    logic [SB-1:0]             r_alpha;
    logic [SB-1:0]             r_beta;

    // table status
    logic [CNT_W-1:0]          r_cap_eff;
    logic [CNT_W-1:0]          r_occ, n_occ;
    logic [dpkv_pkg::HIT_W-1:0] r_hits;

    // scan state
    logic [CNT_W-1:0] r_idx;
    logic             r_pend;
    logic [AW-1:0]    r_pend_idx;
    logic             r_match;
    logic [AW-1:0]    r_match_idx;
    logic [HB-1:0]    r_m_height;
    logic [SB-1:0]    r_m_best;
    logic [SB-1:0]    r_m_alpha;
    logic [SB-1:0]    r_m_beta;
    logic             r_min_vld;
    logic [KW-1:0]    r_min_key;
    logic [AW-1:0]    r_min_idx;

    // ram ports
    logic             rd_en;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [KW-1:0]    rd_key;
    logic [HB-1:0]    rd_height;
    logic [SB-1:0]    rd_best;
    logic [SB-1:0]    rd_alpha;
    logic [SB-1:0]    rd_beta;
    logic             key_eq;
    logic             key_lt;
    logic             hit;

    logic [WW-1:0]    cfg_ext;
    logic [CNT_W-1:0] cap_new;

    logic             div_start;
    logic             div_done;

    // entry fields from the ram read port
    assign rd_key    = rd_data[ENT_W-1 -: KW];
    assign rd_height = rd_data[3*SB +: HB];
    assign rd_best   = rd_data[2*SB +: SB];
    assign rd_alpha  = rd_data[SB +: SB];
    assign rd_beta   = rd_data[0 +: SB];

    // key compares: match against the command key, order against the minimum
    assign key_eq = (rd_key == r_key);
    assign key_lt = !r_min_vld || (rd_key < r_min_key);

    assign rd_en   = (r_state == S_SCAN) && (r_idx < r_occ);
    assign wr_data = {r_key, r_height, r_best, r_alpha, r_beta};
    assign hit     = r_match && (r_m_height >= r_height);

    // capacity clamp to one .. table size
    always_comb begin
        cfg_ext = WW'(i_cfg_wdata);
        if (cfg_ext == '0) begin
            cap_new = CNT_W'(1);
        end else if (cfg_ext > WW'(ENTRIES)) begin
            cap_new = CNT_W'(ENTRIES);
        end else begin
            cap_new = cfg_ext[CNT_W-1:0];
        end
    end

    // store decision: overwrite on greater height, insert, or evict the smallest key when it is below the new key
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_match_idx;
        n_occ   = r_occ;
        if (r_state == S_ACT && r_op == dpkv_pkg::OP_STORE) begin
            if (r_match) begin
                wr_en = (r_m_height < r_height);
            end else if (r_occ < r_cap_eff) begin
                wr_en   = 1'b1;
                wr_addr = r_occ[AW-1:0];
                n_occ   = r_occ + 1'b1;
            end else if (r_min_vld && (r_min_key < r_key)) begin
                wr_en   = 1'b1;
                wr_addr = r_min_idx;
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == dpkv_pkg::OP_LOOKUP || i_op == dpkv_pkg::OP_STORE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_ACT;
                    end
                end
            end
            S_SCAN: begin
                if (!rd_en && !r_pend) begin
                    n_state = S_ACT;
                end
            end
            S_ACT:   n_state = S_DIVGO;
            S_DIVGO: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capacity, occupancy and hit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_eff <= CNT_W'(CAP_INIT);
            r_occ     <= '0;
            r_hits    <= '0;
        end else if (i_cfg_we) begin
            r_cap_eff <= cap_new;
            r_occ     <= '0;
            r_hits    <= '0;
        end else if (r_state == S_ACT) begin
            if (r_op == dpkv_pkg::OP_CLEAR) begin
                r_occ  <= '0;
                r_hits <= '0;
            end else begin
                r_occ <= n_occ;
                if (r_op == dpkv_pkg::OP_LOOKUP && hit && r_hits != '1) begin
                    r_hits <= r_hits + 1'b1;
                end
            end
        end
    end

    // command capture on transfer
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op     <= i_op;
            r_key    <= i_key;
            r_height <= i_height;
            r_best   <= i_best_value;
            r_alpha  <= i_alpha;
            r_beta   <= i_beta;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_match   <= 1'b0;
            r_min_vld <= 1'b0;
            r_idx     <= '0;
        end else if (r_state == S_IDLE) begin
            r_pend    <= 1'b0;
            r_match   <= 1'b0;
            r_min_vld <= 1'b0;
            r_idx     <= '0;
        end else if (r_state == S_SCAN) begin
            r_pend <= rd_en;
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend && key_eq) begin
                r_match <= 1'b1;
            end
            if (r_pend && key_lt) begin
                r_min_vld <= 1'b1;
            end
        end
    end

    // scan payload: matched entry and running minimum
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_pend_idx <= r_idx[AW-1:0];
            if (r_pend && key_eq) begin
                r_match_idx <= r_pend_idx;
                r_m_height  <= rd_height;
                r_m_best    <= rd_best;
                r_m_alpha   <= rd_alpha;
                r_m_beta    <= rd_beta;
            end
            if (r_pend && key_lt) begin
                r_min_key <= rd_key;
                r_min_idx <= r_pend_idx;
            end
        end
    end

    // lookup result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACT) begin
            if (r_op == dpkv_pkg::OP_LOOKUP && hit) begin
                o_found          <= 1'b1;
                o_best_value_out <= r_m_best;
                o_alpha_out      <= r_m_alpha;
                o_beta_out       <= r_m_beta;
            end else begin
                o_found          <= 1'b0;
                o_best_value_out <= '0;
                o_alpha_out      <= '0;
                o_beta_out       <= '0;
            end
        end
    end

    // entry store
    dpkv_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // usage divider
    dpkv_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_count   (r_occ),
        .i_divisor (r_cap_eff),
        .o_done    (div_done),
        .o_quot    (o_usage_per_mil)
    );

    // handshake and counters
    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_entry_count = r_occ;
    assign o_hit_count   = r_hits;

endmodule

`default_nettype wire

[rtl/dpkv_checker.sv]
// port-level checks of the key/value table, bound to the top level
`default_nettype none

module dpkv_assertions #(
    parameter int ENTRIES     = dpkv_pkg::ENTRIES_DEF,
    parameter int SCORE_BITS  = dpkv_pkg::SCORE_BITS_DEF,
    localparam int CNT_W      = $clog2(ENTRIES + 1)
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_valid,
    input wire logic                         o_found,
    input wire logic [SCORE_BITS-1:0]        o_best_value_out,
    input wire logic [SCORE_BITS-1:0]        o_alpha_out,
    input wire logic [SCORE_BITS-1:0]        o_beta_out,
    input wire logic [CNT_W-1:0]             o_entry_count,
    input wire logic [dpkv_pkg::USAGE_W-1:0] o_usage_per_mil
);

    // an accepted command keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // the result strobe lasts one cycle and frees the block
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe longer than one cycle");

    // a result only appears while a command is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result without a command in flight");

    // a miss reports zero values
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |->
        (o_best_value_out == '0 && o_alpha_out == '0 && o_beta_out == '0))
        else $error("nonzero values on a miss");

    // usage stays within range and the count within the table
    a_usage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_usage_per_mil <= dpkv_pkg::USAGE_W'(dpkv_pkg::PER_MIL)
                     && o_entry_count <= CNT_W'(ENTRIES)))
        else $error("usage or entry count out of range");

endmodule

bind depth_preferred_key_value_table dpkv_assertions #(
    .ENTRIES     (ENTRIES),
    .SCORE_BITS  (SCORE_BITS)
) u_dpkv_assertions (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_found          (o_found),
    .o_best_value_out (o_best_value_out),
    .o_alpha_out      (o_alpha_out),
    .o_beta_out       (o_beta_out),
    .o_entry_count    (o_entry_count),
    .o_usage_per_mil  (o_usage_per_mil)
);

`default_nettype wire

[test/dpkv_checker.sv]
// checker for the depth-preferred key/value table: predicts every result and compares it
`default_nettype none

module dpkv_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration and command side
    input  wire logic                             i_cfg_we,
    input  wire logic [dpkv_pkg::CAP_W-1:0]       i_cfg_wdata,
    input  wire logic                             i_start,
    input  wire logic                             i_busy,
    input  wire logic [dpkv_pkg::OP_W-1:0]        i_op,
    input  wire logic [dpkv_pkg::KEY_W-1:0]       i_key,
    input  wire logic [7:0]                       i_height,
    input  wire logic [15:0]                      i_best_value,
    input  wire logic [15:0]                      i_alpha,
    input  wire logic [15:0]                      i_beta,
    // result side
    input  wire logic                             i_valid,
    input  wire logic                             i_found,
    input  wire logic [15:0]                      i_best_value_out,
    input  wire logic [15:0]                      i_alpha_out,
    input  wire logic [15:0]                      i_beta_out,
    input  wire logic [dpkv_pkg::CAP_W-1:0]       i_entry_count,
    input  wire logic [dpkv_pkg::HIT_W-1:0]       i_hit_count,
    input  wire logic [dpkv_pkg::USAGE_W-1:0]     i_usage_per_mil,
    // status for the stimulus side
    output int                                    o_fail_count,
    output int                                    o_outstanding,
    output int                                    o_results,
    output int                                    o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  height;
        logic [15:0] best;
        logic [15:0] low_bound;
        logic [15:0] high_bound;
    } t_slot;

    typedef struct packed {
        logic                           found;
        logic [15:0]                    best;
        logic [15:0]                    alpha;
        logic [15:0]                    beta;
        logic [dpkv_pkg::CAP_W-1:0]     count;
        logic [dpkv_pkg::HIT_W-1:0]     hits;
        logic [dpkv_pkg::USAGE_W-1:0]   usage;
    } t_outcome;

    // predicted table contents, ordered by key so the smallest key is first
    t_slot          held [logic [dpkv_pkg::KEY_W-1:0]];
    int unsigned    capacity_reg;
    logic [dpkv_pkg::HIT_W-1:0] hit_total;
    t_outcome       awaited_outcomes [$];
    int             fails;
    int             results;
    int             hits;

    initial begin
        fails         = 0;
        results       = 0;
        hits          = 0;
        capacity_reg  = dpkv_pkg::CAP_RESET;
        hit_total     = '0;
        o_fail_count  = 0;
        o_outstanding = 0;
        o_results     = 0;
        o_hits        = 0;
    end

    function automatic int unsigned eff_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > dpkv_pkg::ENTRIES_DEF) c = dpkv_pkg::ENTRIES_DEF;
        return c;
    endfunction

    function automatic void empty_table();
        held.delete();
        hit_total = '0;
    endfunction

    // apply one command to the predicted table and return what the block should report
    function automatic t_outcome predict_outcome(logic [dpkv_pkg::OP_W-1:0] op,
                                                 logic [dpkv_pkg::KEY_W-1:0] key,
                                                 logic [7:0] height, logic [15:0] best,
                                                 logic [15:0] lo, logic [15:0] hi);
        t_outcome r;
        t_slot e;
        logic [dpkv_pkg::KEY_W-1:0] low_key;
        r = '0;
        e = '{height: height, best: best, low_bound: lo, high_bound: hi};
        case (op)
            dpkv_pkg::OP_LOOKUP: begin
                if (held.exists(key) && held[key].height >= height) begin
                    r.found = 1'b1;
                    r.best  = held[key].best;
                    r.alpha = held[key].low_bound;
                    r.beta  = held[key].high_bound;
                    if (hit_total != '1) hit_total = hit_total + 1'b1;
                end
            end
            dpkv_pkg::OP_STORE: begin
                if (held.exists(key)) begin
                    // depth preferred: only a deeper search replaces an entry
                    if (held[key].height < height) held[key] = e;
                end else if (held.num() < eff_capacity()) begin
                    held[key] = e;
                end else begin
                    // full: the smallest key of the held ones and the new one goes
                    void'(held.first(low_key));
                    if (low_key < key) begin
                        held.delete(low_key);
                        held[key] = e;
                    end
                end
            end
            dpkv_pkg::OP_CLEAR: empty_table();
            default: ;
        endcase
        r.count = dpkv_pkg::CAP_W'(held.num());
        r.hits  = hit_total;
        r.usage = dpkv_pkg::USAGE_W'((held.num() * dpkv_pkg::PER_MIL) / eff_capacity());
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h (result %0d)",
                                      name, got, want, results));
    endtask

    // watch result, configuration and command transfers at each edge
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            capacity_reg = dpkv_pkg::CAP_RESET;
            empty_table();
            awaited_outcomes.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result transfer with no command outstanding");
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("found", 32'(i_found), 32'(want.found));
                    compare_field("best_value_out", 32'(i_best_value_out), 32'(want.best));
                    compare_field("alpha_out", 32'(i_alpha_out), 32'(want.alpha));
                    compare_field("beta_out", 32'(i_beta_out), 32'(want.beta));
                    compare_field("entry_count", 32'(i_entry_count), 32'(want.count));
                    compare_field("hit_count", i_hit_count, want.hits);
                    compare_field("usage_per_mil", 32'(i_usage_per_mil), 32'(want.usage));
                    if (want.found) hits++;
                end
                results++;
            end
            if (i_cfg_we) begin
                capacity_reg = i_cfg_wdata;
                empty_table();
            end
            if (i_start && !i_busy)
                awaited_outcomes.push_back(predict_outcome(i_op, i_key, i_height,
                                                           i_best_value, i_alpha, i_beta));
        end
        o_fail_count  <= fails;
        o_outstanding <= awaited_outcomes.size();
        o_results     <= results;
        o_hits        <= hits;
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// top of the key/value table test: clock, reset, command stimulus and verdict
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // code the block leaves unused
    localparam logic [dpkv_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 88;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [dpkv_pkg::CAP_W-1:0]       i_cfg_wdata = '0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [dpkv_pkg::OP_W-1:0]        i_op = '0;
    logic [dpkv_pkg::KEY_W-1:0]       i_key = '0;
    logic [7:0]                       i_height = '0;
    logic signed [15:0]               i_best_value = '0;
    logic signed [15:0]               i_alpha = '0;
    logic signed [15:0]               i_beta = '0;
    logic                             o_valid;
    logic                             o_found;
    logic signed [15:0]               o_best_value_out;
    logic signed [15:0]               o_alpha_out;
    logic signed [15:0]               o_beta_out;
    logic [dpkv_pkg::CAP_W-1:0]       o_entry_count;
    logic [dpkv_pkg::HIT_W-1:0]       o_hit_count;
    logic [dpkv_pkg::USAGE_W-1:0]     o_usage_per_mil;

    int fail_count;
    int outstanding;
    int results;
    int hits;
    int commands = 0;
    int settings = 0;
    bit no_gaps = 1'b0;

    always #10 i_clk = ~i_clk;

    depth_preferred_key_value_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_height         (i_height),
        .i_best_value     (i_best_value),
        .i_alpha          (i_alpha),
        .i_beta           (i_beta),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_best_value_out (o_best_value_out),
        .o_alpha_out      (o_alpha_out),
        .o_beta_out       (o_beta_out),
        .o_entry_count    (o_entry_count),
        .o_hit_count      (o_hit_count),
        .o_usage_per_mil  (o_usage_per_mil)
    );

    dpkv_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (start),
        .i_busy           (busy),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_height         (i_height),
        .i_best_value     (i_best_value),
        .i_alpha          (i_alpha),
        .i_beta           (i_beta),
        .i_valid          (o_valid),
        .i_found          (o_found),
        .i_best_value_out (o_best_value_out),
        .i_alpha_out      (o_alpha_out),
        .i_beta_out       (o_beta_out),
        .i_entry_count    (o_entry_count),
        .i_hit_count      (o_hit_count),
        .i_usage_per_mil  (o_usage_per_mil),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_results        (results),
        .o_hits           (hits)
    );

    // one command transfer; called just after a rising edge
    task automatic send_cmd(logic [dpkv_pkg::OP_W-1:0] op, logic [dpkv_pkg::KEY_W-1:0] key,
                            logic [7:0] height, logic [15:0] best, logic [15:0] lo,
                            logic [15:0] hi);
        if (!no_gaps && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_key        <= key;
        i_height     <= height;
        i_best_value <= best;
        i_alpha      <= lo;
        i_beta       <= hi;
        do @(posedge i_clk); while (busy);
        commands++;
    endtask

    // hold commands back until every result has come
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(logic [dpkv_pkg::CAP_W-1:0] cap);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    // random phase: mostly a small key pool so stores, hits and evictions interact
    task automatic random_phase(logic [dpkv_pkg::CAP_W-1:0] cap, int count);
        logic [dpkv_pkg::KEY_W-1:0] pool [];
        logic [dpkv_pkg::KEY_W-1:0] key;
        logic [dpkv_pkg::OP_W-1:0]  op;
        logic [7:0]                 height;
        int unsigned                pick;
        int                         pool_size;
        write_capacity(cap);
        pool_size = (cap == 0) ? 4 : ((cap > 24) ? 48 : 2 * cap + 2);
        pool = new[pool_size];
        foreach (pool[i]) pool[i] = {$urandom, $urandom};
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 46)      op = dpkv_pkg::OP_LOOKUP;
            else if (pick < 95) op = dpkv_pkg::OP_STORE;
            else if (pick < 98) op = dpkv_pkg::OP_CLEAR;
            else                op = OP_UNUSED;
            if ($urandom_range(99) < 85) key = pool[$urandom_range(pool_size - 1)];
            else                         key = {$urandom, $urandom};
            height = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom);
            send_cmd(op, key, height, 16'($urandom), 16'($urandom), 16'($urandom));
            if (n == count / 2 && $urandom_range(1)) drain();
        end
    endtask

    initial begin
        logic [dpkv_pkg::CAP_W-1:0] caps [13];
        caps = '{11'd16, 11'd4, 11'd1, 11'd2, 11'd8, 11'd32, 11'd3, 11'd1024,
                 11'd2047, 11'd0, 11'd64, 11'd5, 11'd12};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset capacity, extreme keys, heights and scores
        send_cmd(dpkv_pkg::OP_LOOKUP, '0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_STORE, '0, 8'd0, 16'h8000, 16'h8000, 16'h8000);
        send_cmd(dpkv_pkg::OP_STORE, '1, 8'd255, 16'h7fff, 16'h7fff, 16'h7fff);
        send_cmd(dpkv_pkg::OP_LOOKUP, '0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_LOOKUP, '1, 8'd255, 16'hffff, 16'hffff, 16'hffff);
        send_cmd(dpkv_pkg::OP_LOOKUP, '0, 8'd1, 16'h0000, 16'h0000, 16'h0000);
        // same height does not replace, a deeper one does
        send_cmd(dpkv_pkg::OP_STORE, '0, 8'd0, 16'h1234, 16'h0001, 16'h0002);
        send_cmd(dpkv_pkg::OP_LOOKUP, '0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_STORE, '0, 8'd5, 16'h5a5a, 16'ha5a5, 16'h0ff0);
        send_cmd(dpkv_pkg::OP_LOOKUP, '0, 8'd5, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(OP_UNUSED, '1, 8'd255, 16'hffff, 16'hffff, 16'hffff);
        send_cmd(dpkv_pkg::OP_CLEAR, '0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_LOOKUP, '1, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        // capacity zero acts as one: the smallest key is dropped, new one included
        write_capacity(11'd0);
        send_cmd(dpkv_pkg::OP_STORE, 64'd5, 8'd3, 16'h0005, 16'h0005, 16'h0005);
        send_cmd(dpkv_pkg::OP_STORE, 64'd3, 8'd3, 16'h0003, 16'h0003, 16'h0003);
        send_cmd(dpkv_pkg::OP_STORE, 64'd9, 8'd3, 16'h0009, 16'h0009, 16'h0009);
        send_cmd(dpkv_pkg::OP_LOOKUP, 64'd9, 8'd3, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_LOOKUP, 64'd5, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_LOOKUP, 64'd3, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        // capacity above the table size saturates
        write_capacity(11'd2047);
        send_cmd(dpkv_pkg::OP_STORE, 64'h8000_0000_0000_0000, 8'd1,
                 16'h4000, 16'hc000, 16'h0001);
        send_cmd(dpkv_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 8'd1,
                 16'h0000, 16'h0000, 16'h0000);
        send_cmd(dpkv_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 8'd2,
                 16'h0000, 16'h0000, 16'h0000);

        // random phases over several capacities, one of them without gaps
        foreach (caps[p]) begin
            no_gaps = (p == 5);
            random_phase(caps[p], RANDOM_PER_PHASE);
        end
        no_gaps = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        $display("sent %0d commands under %0d capacity settings", commands, settings + 1);
        $display("checked %0d results, %0d of them lookup hits", results, hits);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // guard against a hang
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
